>>> rtl/core/stable_priority_queue_assert.svh
// Assertion macros used by the queue RTL.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

>>> rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int unsigned SpqCapacity = 16;

  // Request codes.
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // Response status codes.
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
    logic [7:0]         priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [7:0]         out_priority;
    logic               is_empty;
  } spq_rsp_t;

  // Contents of one slot as seen by its neighbors.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic [7:0]         prio;
  } spq_slot_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic signed [31:0] value;
    logic [7:0]         prio;
  } spq_cmd_t;

endpackage

>>> rtl/core/spq_req_if.sv
interface spq_req_if;
  import spq_pkg::*;

  logic     valid;
  logic     ready;
  spq_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/spq_rsp_if.sv
interface spq_rsp_if;
  import spq_pkg::*;

  logic     valid;
  logic     ready;
  spq_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/spq_cell.sv
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  spq_pkg::spq_slot_t left_i,
  input  logic              left_ins_i,
  input  spq_pkg::spq_slot_t right_i,
  output spq_pkg::spq_slot_t slot_o,
  output logic              ins_o
);
  import spq_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;
  logic [7:0]         prio_q, prio_d;

  // A new entry lands at or ahead of this slot when the slot is free or
  // holds a strictly lower priority.
  assign ins_o = !valid_q || (prio_q < cmd_i.prio);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.pop) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      prio_d  = right_i.prio;
    end else if (cmd_i.push && ins_o) begin
      if (left_ins_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
        prio_d  = left_i.prio;
      end else begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
        prio_d  = cmd_i.prio;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign slot_o = '{valid: valid_q, value: value_q, prio: prio_q};

endmodule

>>> rtl/core/stable_priority_queue.sv
// Channel  Direction  Payload                                      Handshake
// req_i    in         req_type, value, priority_req                valid / ready
// rsp_o    out        status, out_value, out_priority, is_empty    valid / ready
//
// Each request is applied to the cell row in the cycle it is accepted, and its
// response is in the output register in the next cycle: one item per cycle unless
// a response stalls. The row of cells is the only storage; one compare per cell
// sets that figure. Reset empties the queue at once; no clearing pass is needed.
// A request is accepted while the output register is empty or being drained, so
// a stalled response holds the input back.
`include "stable_priority_queue_assert.svh"

module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::SpqCapacity
) (
  input logic       clk_i,
  input logic       rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  // The queue is a row of cells. Slot 0 holds the next entry to leave and
  // the valid flags always form a run of ones starting at slot 0, so the
  // empty and full flags are read directly from the first and last valid flags.
  spq_slot_t             slot   [CAPACITY];
  logic [CAPACITY-1:0]   ins;
  logic [CAPACITY-1:0]   valid_vec;
  spq_cmd_t              cmd;

  logic     accept;
  logic     q_empty;
  logic     q_full;
  logic     push_go;
  logic     pop_go;
  logic     rsp_valid_q;
  spq_rsp_t rsp_q, rsp_d;

  assign q_empty = !valid_vec[0];
  assign q_full  = valid_vec[CAPACITY-1];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Rejected pushes and pops on an empty queue leave the cells untouched.
  assign push_go = accept && (req_i.data.req_type == ReqPush) && !q_full;
  assign pop_go  = accept && (req_i.data.req_type == ReqPop) && !q_empty;

  assign cmd = '{push: push_go, pop: pop_go,
                 value: req_i.data.value, prio: req_i.data.priority_req};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_slot_t left_slot;
    spq_slot_t right_slot;
    logic      left_ins;

    if (i == 0) begin : g_head
      // Nothing sits ahead of slot 0, so a new entry that lands here is
      // written from the request.
      assign left_slot = '0;
      assign left_ins  = 1'b0;
    end else begin : g_body
      assign left_slot = slot[i-1];
      assign left_ins  = ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slot[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     (left_slot),
      .left_ins_i (left_ins),
      .right_i    (right_slot),
      .slot_o     (slot[i]),
      .ins_o      (ins[i])
    );

    assign valid_vec[i] = slot[i].valid;
  end

  // The response is formed from the cell contents before the update.
  always_comb begin
    rsp_d = '{status: StatusDone, out_value: '0, out_priority: '0, is_empty: 1'b0};
    if (req_i.data.req_type == ReqPop) begin
      if (q_empty) begin
        rsp_d.status   = StatusEmpty;
        rsp_d.is_empty = 1'b1;
      end else begin
        rsp_d.out_value    = slot[0].value;
        rsp_d.out_priority = slot[0].prio;
        rsp_d.is_empty     = !valid_vec[1];
      end
    end else if (q_full) begin
      rsp_d.status = StatusFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Occupied slots must stay packed toward the head of the row.
  logic [CAPACITY:0] valid_ext;
  logic              packed_ok;

  assign valid_ext = {1'b0, valid_vec};
  assign packed_ok = ((valid_ext + 1'b1) & valid_ext) == '0;

  `SPQ_ASSERT_IMP(a_slots_packed, clk_i, rst_ni, 1'b1, packed_ok)
  `SPQ_ASSERT_NXT(a_push_grows, clk_i, rst_ni, push_go,
                  $countones(valid_vec) == $countones($past(valid_vec)) + 1)
  `SPQ_ASSERT_NXT(a_pop_shrinks, clk_i, rst_ni, pop_go,
                  $countones(valid_vec) + 1 == $countones($past(valid_vec)))
  `SPQ_ASSERT_NXT(a_empty_pop_flag, clk_i, rst_ni,
                  accept && (req_i.data.req_type == ReqPop) && q_empty,
                  rsp_o.valid && (rsp_o.data.status == StatusEmpty))

endmodule

>>> dv/stable_priority_queue_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the queue, keeps its own sorted copy of the stored
// entries and compares every response against the oldest predicted one.
module stable_priority_queue_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  spq_pkg::spq_req_t req_data_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  spq_pkg::spq_rsp_t rsp_data_i,
  output int unsigned       errors_o,
  output int unsigned       outstanding_o,
  output int unsigned       requests_o,
  output int unsigned       served_pops_o,
  output int unsigned       empty_pops_o,
  output int unsigned       full_pushes_o,
  output int unsigned       peak_fill_o
);
  import spq_pkg::*;

  localparam int Depth = SpqCapacity;

  logic signed [31:0] slot_value [Depth];
  logic [7:0]         slot_prio  [Depth];
  int                 fill;
  spq_rsp_t           due_rsp [$];

  // Applies one request to the local copy and returns the response it causes.
  function automatic spq_rsp_t serve_request(input spq_req_t req);
    spq_rsp_t rsp;
    int       pos;
    rsp = '0;
    if (req.req_type == ReqPop) begin
      if (fill == 0) begin
        rsp.status = StatusEmpty;
      end else begin
        rsp.status       = StatusDone;
        rsp.out_value    = slot_value[0];
        rsp.out_priority = slot_prio[0];
        for (int i = 1; i < fill; i++) begin
          slot_value[i-1] = slot_value[i];
          slot_prio[i-1]  = slot_prio[i];
        end
        fill--;
      end
    end else if (fill >= Depth) begin
      rsp.status = StatusFull;
    end else begin
      // The new entry lands in front of the first strictly lower priority.
      pos = fill;
      for (int i = 0; i < fill; i++) begin
        if (pos == fill && slot_prio[i] < req.priority_req) pos = i;
      end
      for (int i = fill; i > pos; i--) begin
        slot_value[i] = slot_value[i-1];
        slot_prio[i]  = slot_prio[i-1];
      end
      slot_value[pos] = req.value;
      slot_prio[pos]  = req.priority_req;
      fill++;
    end
    rsp.is_empty = (fill == 0);
    return rsp;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spq_rsp_t want;
    if (!rst_ni) begin
      fill = 0;
      due_rsp.delete();
      errors_o      = 0;
      outstanding_o = 0;
      requests_o    = 0;
      served_pops_o = 0;
      empty_pops_o  = 0;
      full_pushes_o = 0;
      peak_fill_o   = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (due_rsp.size() == 0) begin
          errors_o++;
          $display("%0t ns: response with none expected, got status %0d value %0h",
                   $time, rsp_data_i.status, rsp_data_i.out_value);
        end else begin
          want = due_rsp.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_data_i.status));
          compare_field("out_value", want.out_value, rsp_data_i.out_value);
          compare_field("out_priority", 32'(want.out_priority),
                        32'(rsp_data_i.out_priority));
          compare_field("is_empty", 32'(want.is_empty), 32'(rsp_data_i.is_empty));
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = serve_request(req_data_i);
        due_rsp.push_back(want);
        requests_o++;
        if (req_data_i.req_type == ReqPop && want.status == StatusDone) served_pops_o++;
        if (want.status == StatusEmpty) empty_pops_o++;
        if (want.status == StatusFull) full_pushes_o++;
        if (fill > int'(peak_fill_o)) peak_fill_o = unsigned'(fill);
      end
      outstanding_o = due_rsp.size();
    end
  end

endmodule

>>> dv/stable_priority_queue_test.sv
`timescale 1ns / 100ps

// Top of the queue testbench. It drives requests and response back-pressure;
// all prediction and comparison lives in the checker instance beside the block.
module stable_priority_queue_test;
  import spq_pkg::*;

  logic clk_i;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle;
  int unsigned stall_pct;
  // A long receiver hold-off, counted down by the receiver process itself.
  int unsigned hold_cycles;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned requests;
  int unsigned served_pops;
  int unsigned empty_pops;
  int unsigned full_pushes;
  int unsigned peak_fill;

  stable_priority_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  stable_priority_queue_checker u_order_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_data_i    (req_if.data),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_data_i    (rsp_if.data),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .requests_o    (requests),
    .served_pops_o (served_pops),
    .empty_pops_o  (empty_pops),
    .full_pushes_o (full_pushes),
    .peak_fill_o   (peak_fill)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; the slowest correct run is far shorter.
  initial begin
    #2000000;
    $display("Timed out waiting for responses.");
    $display("stable_priority_queue: mismatch");
    $finish;
  end

  // The receiver decides its ready once per cycle, at the falling edge. While a
  // hold-off is running it keeps ready low and counts the hold-off down.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid is left high, so back-to-back items need no gap between them.
  task automatic offer(input logic op, input logic signed [31:0] val,
                       input logic [7:0] prio);
    spq_req_t item;
    item.req_type     = op;
    item.value        = val;
    item.priority_req = prio;
    while ($urandom_range(99) < send_idle) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.data  = item;
    req_if.valid = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted response has come back.
  task automatic settle();
    req_if.valid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  // One random item. The mode steers the queue towards full, towards empty or
  // keeps it around its current level, so that long runs of well-formed traffic
  // reach deep fill levels and the full and empty corners both come up often.
  // Priorities mostly come from a narrow band so that ties are common.
  task automatic random_item(input int mode);
    int unsigned push_pct;
    int unsigned pick;
    logic [7:0]  prio;
    push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
    pick = $urandom_range(9);
    if (pick < 6)       prio = 8'($urandom_range(3));
    else if (pick < 8)  prio = 8'($urandom);
    else if (pick == 8) prio = 8'd0;
    else                prio = 8'd255;
    if ($urandom_range(99) < push_pct) offer(ReqPush, $urandom, prio);
    else offer(ReqPop, $urandom, prio);
  endtask

  task automatic random_run(input int count);
    int mode;
    mode = 2;
    for (int n = 0; n < count; n++) begin
      if (n % 24 == 0) mode = $urandom_range(2);
      random_item(mode);
    end
  endtask

  initial begin
    logic signed [31:0] val;
    logic [7:0]         prio;

    req_if.valid = 1'b0;
    req_if.data  = '0;
    send_idle    = 0;
    stall_pct    = 0;
    hold_cycles  = 0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. A pop straight after reset finds the queue empty.
    offer(ReqPop, 32'sd0, 8'd0);
    // Sixteen pushes fill the queue. The priorities repeat the top, bottom and a
    // middle value twice, so entries of equal priority must keep push order;
    // the first values are the extremes of the data word.
    for (int i = 0; i < SpqCapacity; i++) begin
      case (i)
        0:       val = 32'sh7fff_ffff;
        1:       val = 32'sh8000_0000;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      case (i % 4)
        0:       prio = 8'd255;
        1:       prio = 8'd0;
        default: prio = 8'd128;
      endcase
      offer(ReqPush, val, prio);
    end
    // The queue is full now, so this push is refused and changes nothing.
    offer(ReqPush, 32'sh1234_5678, 8'd255);
    // Pops return the highest priorities first and ties in push order.
    repeat (7) offer(ReqPop, 32'sd0, 8'd0);
    settle();

    // Random part, no idling on either side. Halfway through, the receiver
    // holds off for a long stretch while items keep coming, so its output
    // register fills up and the input stalls.
    random_run(100);
    hold_cycles = 300;
    random_run(100);
    settle();

    // Sender idle about two thirds of the time.
    send_idle = 66;
    random_run(200);
    settle();

    // Receiver stalling about two thirds of the time.
    send_idle = 0;
    stall_pct = 66;
    random_run(200);
    settle();

    // Both sides idle now and then.
    send_idle = 22;
    stall_pct = 22;
    random_run(200);

    req_if.valid = 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d requests; peak fill %0d of %0d entries.",
             requests, peak_fill, SpqCapacity);
    $display("Pops served %0d, pops on empty %0d, pushes refused when full %0d.",
             served_pops, empty_pops, full_pushes);
    if (errors == 0) begin
      $display("stable_priority_queue: match");
    end else begin
      $display("stable_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
